// File: hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// No dependencies; used by spq_cell and stable_priority_queue.
package spq_pkg;

   localparam int DEF_QUEUE_DEPTH   = 16;
   localparam int DEF_TAG_BITS      = 16;
   localparam int DEF_PRIORITY_BITS = 4;
   localparam int OCCUPANCY_BITS    = 5;
   localparam int STATUS_BITS       = 2;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SERVE  = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_SERVED   = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_DROPPED  = 2'd3
   } status_type;

   // Broadcast command from the top level to every cell of the chain.
   typedef struct packed {
      logic push;
      logic pop;
   } cell_cmd_type;

endpackage

// File: hdl/spq_cell.sv
// One slot of the sorted chain: holds tag, priority and an occupied flag.
// Depends on spq_pkg for the command struct.
module spq_cell #(
   parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
   parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_pkg::cell_cmd_type    cmd,
   input  logic [TAG_BITS-1:0]      new_tag,
   input  logic [PRIORITY_BITS-1:0] new_prio,
   input  logic                     left_keep,
   input  logic [TAG_BITS-1:0]      left_tag,
   input  logic [PRIORITY_BITS-1:0] left_prio,
   input  logic                     left_valid,
   input  logic [TAG_BITS-1:0]      right_tag,
   input  logic [PRIORITY_BITS-1:0] right_prio,
   input  logic                     right_valid,
   output logic                     keep,
   output logic [TAG_BITS-1:0]      tag,
   output logic [PRIORITY_BITS-1:0] prio,
   output logic                     valid
);

   logic [TAG_BITS-1:0]      tag_ff, tag_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic                     valid_ff, valid_in;

   // An entry of equal or better priority stays ahead of the new one.
   assign keep = valid_ff && (prio_ff <= new_prio);

   always_comb begin
      tag_in   = tag_ff;
      prio_in  = prio_ff;
      valid_in = valid_ff;
      if (cmd.push && !keep) begin
         if (left_keep) begin
            tag_in   = new_tag;
            prio_in  = new_prio;
            valid_in = 1'b1;
         end else begin
            // shift one slot toward the tail
            tag_in   = left_tag;
            prio_in  = left_prio;
            valid_in = left_valid;
         end
      end else if (cmd.pop) begin
         tag_in   = right_tag;
         prio_in  = right_prio;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign tag   = tag_ff;
   assign prio  = prio_ff;
   assign valid = valid_ff;

endmodule

// File: hdl/stable_priority_queue.sv
// Top level of the stable priority queue: a chain of spq_cell slots kept
// sorted by priority, with a registered result stage. Depends on spq_pkg.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_mode, req_item_tag, req_item_priority
//   rsp      out        rsp_valid, rsp_ready, rsp_status, rsp_served_tag,
//                       rsp_served_priority, rsp_occupancy
//
// Every cell compares its priority with the new one at once and shifts by one
// slot, so an item is taken per cycle while req_ready is high.
// The result appears in the cycle after acceptance from the result register.
// req_ready is high while the result register is empty or being drained.
// Synchronous reset empties the queue; stored tags need no clearing.
module stable_priority_queue #(
   parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
   parameter int TAG_BITS      = spq_pkg::DEF_TAG_BITS,
   parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [TAG_BITS-1:0]                req_item_tag,
   input  logic [PRIORITY_BITS-1:0]           req_item_priority,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [spq_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic [TAG_BITS-1:0]                rsp_served_tag,
   output logic [PRIORITY_BITS-1:0]           rsp_served_priority,
   output logic [spq_pkg::OCCUPANCY_BITS-1:0] rsp_occupancy
);

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_BITS = spq_pkg::OCCUPANCY_BITS;

   logic [TAG_BITS-1:0]      cell_tag   [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];
   logic                     cell_valid [QUEUE_DEPTH];
   logic                     cell_keep  [QUEUE_DEPTH];

   spq_pkg::cell_cmd_type cmd;
   logic                  accept, full, empty;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type              status_ff, status_in;
   logic [TAG_BITS-1:0]              otag_ff, otag_in;
   logic [PRIORITY_BITS-1:0]         oprio_ff, oprio_in;
   logic [CNT_BITS-1:0]              ocount_ff;
   logic [CNT_BITS+OCC_BITS-1:0]     ocount_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = cell_valid[QUEUE_DEPTH-1];
   assign empty     = !cell_valid[0];

   assign cmd.push = accept && (req_mode == spq_pkg::MODE_INSERT) && !full;
   assign cmd.pop  = accept && (req_mode == spq_pkg::MODE_SERVE) && !empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                     l_keep, l_valid, r_valid;
      logic [TAG_BITS-1:0]      l_tag, r_tag;
      logic [PRIORITY_BITS-1:0] l_prio, r_prio;

      if (i == 0) begin : g_head
         assign l_keep  = 1'b1;
         assign l_valid = 1'b0;
         assign l_tag   = '0;
         assign l_prio  = '0;
      end else begin : g_body
         assign l_keep  = cell_keep[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_tag   = cell_tag[i-1];
         assign l_prio  = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_tag   = '0;
         assign r_prio  = '0;
      end else begin : g_inner
         assign r_valid = cell_valid[i+1];
         assign r_tag   = cell_tag[i+1];
         assign r_prio  = cell_prio[i+1];
      end

      spq_cell #(
         .TAG_BITS      (TAG_BITS),
         .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_tag     (req_item_tag),
         .new_prio    (req_item_priority),
         .left_keep   (l_keep),
         .left_tag    (l_tag),
         .left_prio   (l_prio),
         .left_valid  (l_valid),
         .right_tag   (r_tag),
         .right_prio  (r_prio),
         .right_valid (r_valid),
         .keep        (cell_keep[i]),
         .tag         (cell_tag[i]),
         .prio        (cell_prio[i]),
         .valid       (cell_valid[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      otag_in      = otag_ff;
      oprio_in     = oprio_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         otag_in      = '0;
         oprio_in     = '0;
         if (req_mode == spq_pkg::MODE_INSERT) begin
            status_in = full ? spq_pkg::STATUS_DROPPED : spq_pkg::STATUS_INSERTED;
         end else if (empty) begin
            status_in = spq_pkg::STATUS_EMPTY;
         end else begin
            status_in = spq_pkg::STATUS_SERVED;
            otag_in   = cell_tag[0];
            oprio_in  = cell_prio[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      otag_ff   <= otag_in;
      oprio_ff  <= oprio_in;
      if (accept) begin
         ocount_ff <= count_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   assign ocount_ext          = {{OCC_BITS{1'b0}}, ocount_ff};
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_served_tag      = otag_ff;
   assign rsp_served_priority = oprio_ff;
   assign rsp_occupancy       = ocount_ext[OCC_BITS-1:0];

endmodule
